/* rtl/tcpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants, codes and types of the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int DEPTH       = 128;
  localparam int HANDLE_BITS = 16;
  localparam int NUM_CLASSES = 3;

  localparam int PORT_HANDLE_W = 16;
  localparam int STORE_W = (HANDLE_BITS < PORT_HANDLE_W) ? HANDLE_BITS : PORT_HANDLE_W;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = $clog2(NUM_CLASSES * DEPTH);

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] CLASS_NONE = 2'd0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [STORE_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic       valid;
    logic       served;
    logic [1:0] status;
    logic [1:0] cls;
  } result_t;

endpackage

/* rtl/tcpq_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_store
// Handle storage for all three rings, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module tcpq_store (
  input  logic                           clk,
  input  tcpq_pkg::store_req_t           req,
  output logic [tcpq_pkg::STORE_W-1:0]   rd_data
);

  logic [tcpq_pkg::STORE_W-1:0] mem [0:tcpq_pkg::NUM_CLASSES*tcpq_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

/* rtl/tcpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Command register, ring pointers, fill counts and strict-priority select.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                mode,
  input  logic [1:0]                          task_class,
  input  logic [tcpq_pkg::PORT_HANDLE_W-1:0]  task_handle,
  output tcpq_pkg::store_req_t                req,
  output tcpq_pkg::result_t                   res
);

  logic                         cmd_valid;
  logic                         cmd_mode;
  logic [1:0]                   cmd_class;
  logic [tcpq_pkg::STORE_W-1:0] cmd_handle;

  logic [tcpq_pkg::PTR_W-1:0] head       [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::PTR_W-1:0] head_next  [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::CNT_W-1:0] count      [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::CNT_W-1:0] count_next [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::PTR_W-1:0] tail       [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::SUM_W-1:0] tail_sum   [tcpq_pkg::NUM_CLASSES];

  tcpq_pkg::result_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= accept;
    end
    if (accept) begin
      cmd_mode   <= mode;
      cmd_class  <= task_class;
      cmd_handle <= task_handle[tcpq_pkg::STORE_W-1:0];
    end
  end

  always_comb begin
    for (int q = 0; q < tcpq_pkg::NUM_CLASSES; q++) begin
      tail_sum[q] = tcpq_pkg::SUM_W'(head[q]) + tcpq_pkg::SUM_W'(count[q]);
      if (tail_sum[q] >= tcpq_pkg::SUM_W'(tcpq_pkg::DEPTH)) begin
        tail[q] = tcpq_pkg::PTR_W'(tail_sum[q] - tcpq_pkg::SUM_W'(tcpq_pkg::DEPTH));
      end else begin
        tail[q] = tcpq_pkg::PTR_W'(tail_sum[q]);
      end
    end
  end

  always_comb begin
    logic found;
    found      = 1'b0;
    head_next  = head;
    count_next = count;
    req        = '0;
    req.wdata  = cmd_handle;
    res_next   = '0;
    res_next.valid = cmd_valid;
    if (cmd_valid) begin
      if (cmd_mode == tcpq_pkg::MODE_ENQ) begin
        if (cmd_class == tcpq_pkg::CLASS_NONE) begin
          res_next.status = tcpq_pkg::ST_INVALID;
        end else begin
          for (int q = 0; q < tcpq_pkg::NUM_CLASSES; q++) begin
            if (cmd_class == 2'(q + 1)) begin
              if (count[q] == tcpq_pkg::CNT_W'(tcpq_pkg::DEPTH)) begin
                res_next.status = tcpq_pkg::ST_FULL;
              end else begin
                req.we   = 1'b1;
                req.addr = tcpq_pkg::ADDR_W'(q * tcpq_pkg::DEPTH)
                         + tcpq_pkg::ADDR_W'(tail[q]);
                count_next[q] = count[q] + tcpq_pkg::CNT_W'(1);
              end
            end
          end
        end
      end else begin
        res_next.status = tcpq_pkg::ST_EMPTY;
        for (int q = 0; q < tcpq_pkg::NUM_CLASSES; q++) begin
          if (!found && count[q] != '0) begin
            found           = 1'b1;
            req.re          = 1'b1;
            req.addr        = tcpq_pkg::ADDR_W'(q * tcpq_pkg::DEPTH)
                            + tcpq_pkg::ADDR_W'(head[q]);
            res_next.status = tcpq_pkg::ST_OK;
            res_next.served = 1'b1;
            res_next.cls    = 2'(q + 1);
            count_next[q]   = count[q] - tcpq_pkg::CNT_W'(1);
            if (head[q] == tcpq_pkg::PTR_W'(tcpq_pkg::DEPTH - 1)) begin
              head_next[q] = '0;
            end else begin
              head_next[q] = head[q] + tcpq_pkg::PTR_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < tcpq_pkg::NUM_CLASSES; q++) begin
        head[q]  <= '0;
        count[q] <= '0;
      end
      res <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      res   <= res_next;
    end
  end

endmodule

/* rtl/three_class_priority_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_priority_queue_unit
// Three FIFO rings of task handles served in strict priority, class 1 first.
// Path: the command register captures the request, then the pointer update
//   registers the result alongside the registered store read, so done and
//   the served handle are valid together.
// Throughput: one transaction per cycle; busy is tied low, done cannot stall.
// Reset: synchronous rst empties all rings; stored handles are not cleared.
// ----------------------------------------------------------------------------
module three_class_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [1:0]  task_class,
  input  logic [15:0] task_handle,
  output logic        done,
  output logic [1:0]  status,
  output logic [1:0]  served_class,
  output logic [15:0] served_handle
);

  tcpq_pkg::store_req_t         req;
  tcpq_pkg::result_t            res;
  logic [tcpq_pkg::STORE_W-1:0] rd_data;

  assign busy = 1'b0;

  tcpq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (start && !busy),
    .mode        (mode),
    .task_class  (task_class),
    .task_handle (task_handle),
    .req         (req),
    .res         (res)
  );

  tcpq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign done          = res.valid;
  assign status        = res.status;
  assign served_class  = res.cls;
  assign served_handle = res.served ? 16'(rd_data) : 16'd0;

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("done without a matching start");

  a_no_serve_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && status != tcpq_pkg::ST_OK) |->
      (served_class == tcpq_pkg::CLASS_NONE && served_handle == 16'd0))
    else $error("served fields set on a refused transaction");

  a_serve_is_ok: assert property (@(posedge clk) disable iff (rst)
    (done && served_class != tcpq_pkg::CLASS_NONE) |-> (status == tcpq_pkg::ST_OK))
    else $error("served class without ok status");
`endif

endmodule
